[hw/rtl/br_pkg.sv]
// ----------------------------------------------------------------------------
// br_pkg - shared types and constants for the byte rotor cipher
// Token layout carried along the rotor cell chain, function codes and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package br_pkg;

    localparam int NUM_ROTORS_DEF = 5;
    localparam int BYTE_W         = 8;
    localparam int SEL_W          = 3;
    localparam int TABLE_DEPTH    = 256;
    localparam int S_TDATA_W      = 24;

    typedef enum logic {
        FUNC_LOAD    = 1'b0,
        FUNC_ENCRYPT = 1'b1
    } t_func;

    // One transaction as it travels down the chain
    typedef struct packed {
        logic              valid;
        t_func             func;
        logic [SEL_W-1:0]  sel;
        logic [BYTE_W-1:0] tpos;
        logic [BYTE_W-1:0] data;
    } t_token;

endpackage

`default_nettype wire

[hw/rtl/br_ram.sv]
// ----------------------------------------------------------------------------
// br_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module br_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/br_odometer.sv]
// ----------------------------------------------------------------------------
// br_odometer - rotor position counters
// Steps the last rotor on every encrypt and ripples wraps towards rotor 0.
// ----------------------------------------------------------------------------
`default_nettype none

module br_odometer #(
    parameter int NUM_ROTORS = br_pkg::NUM_ROTORS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_step,
    output logic [NUM_ROTORS*br_pkg::BYTE_W-1:0]     o_pos
);

    localparam int BW = br_pkg::BYTE_W;

    logic [NUM_ROTORS*BW-1:0] r_pos;
    logic [NUM_ROTORS*BW-1:0] n_pos;

    always_comb begin
        logic carry;
        carry = 1'b1;
        n_pos = r_pos;
        // walk from the last rotor towards rotor 0; drop carry out of rotor 0
        for (int k = NUM_ROTORS - 1; k >= 0; k--) begin
            n_pos[k*BW +: BW] = r_pos[k*BW +: BW] + BW'(carry);
            carry = carry & (r_pos[k*BW +: BW] == {BW{1'b1}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

`default_nettype wire

[hw/rtl/br_cell.sv]
// ----------------------------------------------------------------------------
// br_cell - one rotor of the chain
// Holds one rotor table; writes it for a load addressed here and maps the
// byte of an encrypt through it, then hands the transaction to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module br_cell #(
    parameter int NUM_ROTORS = br_pkg::NUM_ROTORS_DEF,
    parameter int IDX        = 0
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_adv,
    input  wire br_pkg::t_token                      i_tok,
    input  wire logic [NUM_ROTORS*br_pkg::BYTE_W-1:0] i_pos,
    output br_pkg::t_token                           o_tok,
    output logic [NUM_ROTORS*br_pkg::BYTE_W-1:0]     o_pos
);

    localparam int BW = br_pkg::BYTE_W;
    localparam logic [br_pkg::SEL_W-1:0] SEL_IDX = br_pkg::SEL_W'(IDX);

    br_pkg::t_token           r_tok;
    logic [NUM_ROTORS*BW-1:0] r_pos;
    logic                     w_we;
    logic                     w_re;
    logic [BW-1:0]            w_raddr;
    logic [BW-1:0]            w_rdata;

    assign w_we = i_adv && i_tok.valid && (i_tok.func == br_pkg::FUNC_LOAD)
                  && (i_tok.sel == SEL_IDX);
    assign w_re = i_adv && i_tok.valid && (i_tok.func == br_pkg::FUNC_ENCRYPT);
    assign w_raddr = i_tok.data + i_pos[IDX*BW +: BW];

    br_ram #(
        .WIDTH (BW),
        .DEPTH (br_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_tok.tpos),
        .i_wdata (i_tok.data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= i_tok.valid;
        end
        if (i_adv) begin
            r_tok.func <= i_tok.func;
            r_tok.sel  <= i_tok.sel;
            r_tok.tpos <= i_tok.tpos;
            r_tok.data <= i_tok.data;
            r_pos      <= i_pos;
        end
    end

    // substitute the mapped byte for an encrypt
    always_comb begin
        o_tok = r_tok;
        if (r_tok.func == br_pkg::FUNC_ENCRYPT) begin
            o_tok.data = w_rdata;
        end
    end

    assign o_pos = r_pos;

endmodule

`default_nettype wire

[hw/rtl/byte_rotor_cipher.sv]
// ----------------------------------------------------------------------------
// byte_rotor_cipher - byte rotor cipher, odometer stepping
// Chain of rotor cells, one table RAM each, with an output register.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle unless the output stalls and
// delivers a cipher byte once an accepted encrypt has passed one registered
// table read in each rotor cell plus the output register. Load transactions
// (tuser = 0) write at most one rotor table entry, none for an out-of-range
// rotor_select, and produce no output; they travel the chain in order, so a
// load never overtakes or lags an encrypt. Tables must be loaded before use.
// Rotor positions start at zero after reset and are snapshot per encrypt at
// acceptance. An output stall holds the whole chain and drops o_s_tready.
`default_nettype none

module byte_rotor_cipher #(
    parameter int NUM_ROTORS = br_pkg::NUM_ROTORS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [2:0] rotor_select, [10:3] table_position, [18:11] data_byte, rest zero
    input  wire logic [br_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [0] func
    input  wire logic                           i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [7:0] cipher_byte
    output logic [br_pkg::BYTE_W-1:0]           o_m_tdata
);

    localparam int BW = br_pkg::BYTE_W;
    localparam int SW = br_pkg::SEL_W;

    br_pkg::t_token           w_tok [NUM_ROTORS+1];
    logic [NUM_ROTORS*BW-1:0] w_pos [NUM_ROTORS+1];
    logic [NUM_ROTORS*BW-1:0] w_odo_pos;
    logic                     w_adv;
    logic                     w_acc_enc;
    logic                     r_out_valid;
    logic [BW-1:0]            r_out_data;

    assign w_adv     = !r_out_valid || i_m_tready;
    assign w_acc_enc = i_s_tvalid && w_adv && (i_s_tuser == br_pkg::FUNC_ENCRYPT);

    br_odometer #(
        .NUM_ROTORS (NUM_ROTORS)
    ) u_odometer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_acc_enc),
        .o_pos   (w_odo_pos)
    );

    always_comb begin
        w_tok[0].valid = i_s_tvalid;
        w_tok[0].func  = br_pkg::t_func'(i_s_tuser);
        w_tok[0].sel   = i_s_tdata[SW-1:0];
        w_tok[0].tpos  = i_s_tdata[SW +: BW];
        w_tok[0].data  = i_s_tdata[SW+BW +: BW];
    end
    assign w_pos[0] = w_odo_pos;

    for (genvar g = 0; g < NUM_ROTORS; g++) begin : g_cell
        br_cell #(
            .NUM_ROTORS (NUM_ROTORS),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .i_pos   (w_pos[g]),
            .o_tok   (w_tok[g+1]),
            .o_pos   (w_pos[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tok[NUM_ROTORS].valid
                           && (w_tok[NUM_ROTORS].func == br_pkg::FUNC_ENCRYPT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_tok[NUM_ROTORS].data;
        end
    end

    assign o_s_tready = w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // a pending output holds the chain
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while output stalled");

    // last rotor steps once per accepted encrypt
    a_last_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_enc |=> (w_odo_pos[(NUM_ROTORS-1)*BW +: BW]
                       == BW'($past(w_odo_pos[(NUM_ROTORS-1)*BW +: BW]) + 1'b1)))
        else $error("last rotor failed to step");

    // positions move only on an accepted encrypt
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc_enc |=> $stable(w_odo_pos))
        else $error("rotor positions moved without an encrypt");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the byte rotor cipher
// Loads rotor tables and encrypts bytes through the stream ports. A directed
// table covers field extremes, ignored loads and table overwrites. A random
// phase follows in which every encrypt has the table entries on its path
// loaded first. Each cipher byte is checked against a rotor and odometer
// model kept in the bench, or against a fixed byte given in a directed row.
// ----------------------------------------------------------------------------

module testbench;

    localparam int NR          = br_pkg::NUM_ROTORS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PLAN_LEN    = 21;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_COMB,
        RX_SPARSE
    } t_rx_mode;

    typedef struct packed {
        br_pkg::t_func func;
        logic [2:0]    sel;
        logic [7:0]    tpos;
        logic [7:0]    data;
        logic          typed;
        logic [7:0]    cipher;
    } t_plan_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [br_pkg::S_TDATA_W-1:0] i_s_tdata;
    logic                         i_s_tuser;
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [br_pkg::BYTE_W-1:0]    o_m_tdata;

    // Bench copy of the cipher state
    logic [7:0] rotor_tbl [NR][256];
    bit         tbl_set   [NR][256];
    logic [7:0] rotor_pos [NR];
    logic [7:0] cipher_q  [$];

    t_plan_row plan_tbl [PLAN_LEN];

    int  error_count;
    int  cycle_count;
    int  fed_items;
    int  burst_left;
    bit  steady_sender;
    bit  hold_req;

    byte_rotor_cipher #(
        .NUM_ROTORS (NR)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Apply one accepted transaction to the bench state
    function automatic void rotor_update(input br_pkg::t_func f, input logic [2:0] sel,
                                         input logic [7:0] tpos, input logic [7:0] data,
                                         input logic typed, input logic [7:0] typed_val);
        logic [7:0] x;
        logic [7:0] idx;
        bit         carry;
        int         r;
        if (f == br_pkg::FUNC_LOAD) begin
            if (sel < NR) begin
                rotor_tbl[sel][tpos] = data;
                tbl_set[sel][tpos]   = 1'b1;
            end
        end else begin
            x = data;
            for (r = 0; r < NR; r++) begin
                idx = x + rotor_pos[r];
                x   = rotor_tbl[r][idx];
            end
            cipher_q = {cipher_q, (typed ? typed_val : x)};
            // Odometer: last rotor always steps, a wrap carries to the one before
            carry = 1'b1;
            for (r = NR - 1; r >= 0; r--) begin
                if (carry) begin
                    rotor_pos[r] = rotor_pos[r] + 8'd1;
                    carry        = (rotor_pos[r] == 8'd0);
                end
            end
        end
    endfunction

    task automatic send_item(input br_pkg::t_func f, input logic [2:0] sel,
                             input logic [7:0] tpos, input logic [7:0] data,
                             input logic typed, input logic [7:0] typed_val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && !steady_sender) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= {5'b0, data, tpos, sel};
        do @(posedge i_clk); while (!o_s_tready);
        rotor_update(f, sel, tpos, data, typed, typed_val);
        fed_items++;
    endtask

    // Load any entry on the path of this plaintext that was never written
    task automatic fill_path(input logic [7:0] plain);
        logic [7:0] x;
        logic [7:0] idx;
        int         r;
        x = plain;
        for (r = 0; r < NR; r++) begin
            idx = x + rotor_pos[r];
            if (!tbl_set[r][idx])
                send_item(br_pkg::FUNC_LOAD, r[2:0], idx, 8'($urandom_range(0, 255)),
                          1'b0, 8'h00);
            x = rotor_tbl[r][idx];
        end
    endtask

    task automatic drain_results;
        while (cipher_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: stall pattern that changes mode now and then, plus a long hold-off
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        mode       = RX_FREE;
        mode_left  = 0;
        hold_left  = 0;
        phase      = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_FREE:   i_m_tready <= 1'b1;
                    RX_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
                    RX_COMB:   i_m_tready <= (phase % 8) > 2;
                    RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
                    default:   i_m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Output check and cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cipher_q.size() == 0) begin
                $error("cipher_byte: unexpected transaction, actual %0h", o_m_tdata);
                error_count++;
            end else begin
                if (o_m_tdata !== cipher_q[0]) begin
                    $error("cipher_byte: expected %0h, actual %0h", cipher_q[0], o_m_tdata);
                    error_count++;
                end
                void'(cipher_q.pop_front());
            end
        end
    end

    initial begin
        int         i;
        int         r;
        int         pick;
        logic [7:0] plain;
        t_plan_row  row;

        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        fed_items     = 0;
        burst_left    = 0;
        steady_sender = 1'b0;
        hold_req      = 1'b0;
        for (r = 0; r < NR; r++) begin
            rotor_pos[r] = 8'd0;
            for (i = 0; i < 256; i++) begin
                rotor_tbl[r][i] = 8'd0;
                tbl_set[r][i]   = 1'b0;
            end
        end

        // Path for plaintext 0 at reset positions: 0 -> FF -> 00 -> FF -> 80 -> A5
        plan_tbl[0]  = {br_pkg::FUNC_LOAD,    3'd0, 8'h00, 8'hFF, 1'b0, 8'h00};
        plan_tbl[1]  = {br_pkg::FUNC_LOAD,    3'd1, 8'hFF, 8'h00, 1'b0, 8'h00};
        plan_tbl[2]  = {br_pkg::FUNC_LOAD,    3'd2, 8'h00, 8'hFF, 1'b0, 8'h00};
        plan_tbl[3]  = {br_pkg::FUNC_LOAD,    3'd3, 8'hFF, 8'h80, 1'b0, 8'h00};
        plan_tbl[4]  = {br_pkg::FUNC_LOAD,    3'd4, 8'h80, 8'hA5, 1'b0, 8'h00};
        plan_tbl[5]  = {br_pkg::FUNC_ENCRYPT, 3'd0, 8'h00, 8'h00, 1'b1, 8'hA5};
        // Last rotor has stepped once, so the same byte now reads entry 81
        plan_tbl[6]  = {br_pkg::FUNC_LOAD,    3'd4, 8'h81, 8'h5A, 1'b0, 8'h00};
        // Out-of-range rotor selects: drop, tables untouched
        plan_tbl[7]  = {br_pkg::FUNC_LOAD,    3'd5, 8'h00, 8'h00, 1'b0, 8'h00};
        plan_tbl[8]  = {br_pkg::FUNC_LOAD,    3'd6, 8'h81, 8'hFF, 1'b0, 8'h00};
        plan_tbl[9]  = {br_pkg::FUNC_LOAD,    3'd7, 8'hFF, 8'h01, 1'b0, 8'h00};
        plan_tbl[10] = {br_pkg::FUNC_ENCRYPT, 3'd7, 8'hFF, 8'h00, 1'b1, 8'h5A};
        // Overwrite an entry of rotor 0 that an earlier load wrote
        plan_tbl[11] = {br_pkg::FUNC_LOAD,    3'd0, 8'h00, 8'h00, 1'b0, 8'h00};
        plan_tbl[12] = {br_pkg::FUNC_ENCRYPT, 3'd7, 8'hFF, 8'hFF, 1'b0, 8'h00};
        plan_tbl[13] = {br_pkg::FUNC_ENCRYPT, 3'd0, 8'h00, 8'h00, 1'b0, 8'h00};
        plan_tbl[14] = {br_pkg::FUNC_ENCRYPT, 3'd2, 8'h55, 8'h80, 1'b0, 8'h00};
        plan_tbl[15] = {br_pkg::FUNC_ENCRYPT, 3'd5, 8'hAA, 8'h7F, 1'b0, 8'h00};
        plan_tbl[16] = {br_pkg::FUNC_LOAD,    3'd4, 8'hFF, 8'hFF, 1'b0, 8'h00};
        plan_tbl[17] = {br_pkg::FUNC_LOAD,    3'd3, 8'h00, 8'h00, 1'b0, 8'h00};
        plan_tbl[18] = {br_pkg::FUNC_ENCRYPT, 3'd1, 8'h0F, 8'h01, 1'b0, 8'h00};
        plan_tbl[19] = {br_pkg::FUNC_ENCRYPT, 3'd6, 8'hF0, 8'hFE, 1'b0, 8'h00};
        plan_tbl[20] = {br_pkg::FUNC_ENCRYPT, 3'd4, 8'h3C, 8'hFF, 1'b0, 8'h00};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < PLAN_LEN; i++) begin
            row = plan_tbl[i];
            if (row.func == br_pkg::FUNC_ENCRYPT && !row.typed)
                fill_path(row.data);
            send_item(row.func, row.sel, row.tpos, row.data, row.typed, row.cipher);
        end
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        drain_results();

        // Random phase. A carry out of rotor 0 needs 256^5 bytes and is out of reach;
        // carries from the last rotor into the one before it come every 256 bytes.
        while (fed_items < 900) begin
            if (fed_items >= 300 && fed_items < 340) begin
                if (!steady_sender) begin
                    steady_sender = 1'b1;
                    hold_req      = 1'b1;
                end
            end else begin
                steady_sender = 1'b0;
            end
            if (fed_items >= 600 && fed_items < 610 && cipher_q.size() != 0) begin
                i_s_tvalid <= 1'b0;
                burst_left = 0;
                drain_results();
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                plain = 8'($urandom_range(0, 255));
                fill_path(plain);
                send_item(br_pkg::FUNC_ENCRYPT, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), plain, 1'b0, 8'h00);
            end else if (pick < 9) begin
                send_item(br_pkg::FUNC_LOAD, 3'($urandom_range(0, NR - 1)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'b0, 8'h00);
            end else begin
                send_item(br_pkg::FUNC_LOAD, 3'($urandom_range(NR, 7)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'b0, 8'h00);
            end
        end
        i_s_tvalid <= 1'b0;

        drain_results();
        repeat (NR + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
